// File: sv/spq_pkg.sv
package spq_pkg;

    localparam int DEPTH   = 16;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int PRIO_W  = 16;
    localparam int PAY_W   = 32;
    localparam int CNT_W   = 5;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ_CMP,
        S_ENQ_LAST,
        S_DEQ_HEAD,
        S_DEQ_SHIFT
    } state_t;

    typedef struct packed {
        logic              action;
        logic [PRIO_W-1:0] item_priority;
        logic [PAY_W-1:0]  item_payload;
    } cmd_t;

    typedef struct packed {
        status_t           status;
        logic [PRIO_W-1:0] out_priority;
        logic [PAY_W-1:0]  out_payload;
        logic [CNT_W-1:0]  entry_count;
        logic              is_empty;
        logic              is_full;
    } result_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [PAY_W-1:0]  payload;
    } entry_t;

endpackage

// File: sv/sorted_priority_queue.sv
// Channel   Direction  Handshake                  Beat
// command   in         start / busy               cmd_t: action, item_priority, item_payload
// result    out        done (one-cycle strobe)    result_t: status, entry, count, flags
// config    in         capacity_we                capacity_data (5 bits)
//
// One beat is taken at an edge with start high and busy low; its result shows up as a
// one-cycle done strobe after the operation finishes. The store has one read and one
// write port: an enqueue moves each stored entry of lower priority back in turn (or writes
// at once into an empty queue), a dequeue moves every remaining entry forward, and a
// rejected beat finishes at once. Reset clears the count and sets capacity to 16; the store
// itself is never cleared. The receiver cannot stall, so done is never held.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  cmd_t                cmd,
    output logic                done,
    output result_t             result,
    input  logic                capacity_we,
    input  logic [CNT_W-1:0]    capacity_data
);

    // The sorted store: entry 0 is the head and holds the highest priority.
    entry_t             mem [DEPTH];
    entry_t             rdata_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    entry_t             mem_wdata;
    logic [ADDR_W-1:0]  rd_addr;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   capacity_reg;
    logic [CNT_W-1:0]   cap_eff;
    logic [ADDR_W-1:0]  p_reg, p_next;
    cmd_t               op_reg, op_next;
    entry_t             head_reg, head_next;
    result_t            result_reg, result_next;
    logic               done_reg;

    logic               accept;
    logic               finish;
    status_t            fin_status;
    logic               deq_out;
    logic               enq_full;
    logic               store_empty;
    logic               enq_keep;
    logic               deq_last;
    entry_t             cmd_entry;
    entry_t             op_entry;

    assign accept      = start && !busy;
    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign result      = result_reg;

    // Capacity zero acts as one; anything above the store depth saturates to it.
    always_comb
    begin
        if (capacity_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (capacity_reg > CNT_W'(DEPTH))
        begin
            cap_eff = CNT_W'(DEPTH);
        end
        else
        begin
            cap_eff = capacity_reg;
        end
    end

    assign enq_full    = (count_reg >= cap_eff);
    assign store_empty = (count_reg == '0);
    assign cmd_entry   = '{prio: cmd.item_priority, payload: cmd.item_payload};
    assign op_entry    = '{prio: op_reg.item_priority, payload: op_reg.item_payload};
    // Stop the backward walk at the first stored entry of equal or higher priority,
    // which keeps equal priorities in arrival order.
    assign enq_keep    = (rdata_reg.prio >= op_reg.item_priority);
    assign deq_last    = ((CNT_W'(p_reg) + CNT_W'(1)) == (count_reg - CNT_W'(1)));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.action == ACT_ENQ)
                    begin
                        if (!enq_full && !store_empty)
                        begin
                            state_next = S_ENQ_CMP;
                        end
                    end
                    else if (!store_empty)
                    begin
                        state_next = S_DEQ_HEAD;
                    end
                end
            end
            S_ENQ_CMP:
            begin
                if (enq_keep)
                begin
                    state_next = S_IDLE;
                end
                else if (p_reg == ADDR_W'(1))
                begin
                    state_next = S_ENQ_LAST;
                end
            end
            S_ENQ_LAST:
            begin
                state_next = S_IDLE;
            end
            S_DEQ_HEAD:
            begin
                if (count_reg == CNT_W'(1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DEQ_SHIFT;
                end
            end
            S_DEQ_SHIFT:
            begin
                if (deq_last)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // Each cycle reads one entry and writes at most one; while entries are being moved the
    // read runs ahead of the write, so no address is read while it is being written.
    always_comb
    begin
        mem_we     = 1'b0;
        mem_waddr  = p_reg;
        mem_wdata  = op_entry;
        rd_addr    = '0;
        finish     = 1'b0;
        fin_status = STAT_DONE;
        deq_out    = 1'b0;
        count_next = count_reg;
        p_next     = p_reg;
        op_next    = op_reg;
        head_next  = head_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next = cmd;
                    if (cmd.action == ACT_ENQ)
                    begin
                        if (enq_full)
                        begin
                            finish     = 1'b1;
                            fin_status = STAT_FULL;
                        end
                        else if (store_empty)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = '0;
                            mem_wdata  = cmd_entry;
                            finish     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            rd_addr = ADDR_W'(count_reg - CNT_W'(1));
                            p_next  = ADDR_W'(count_reg);
                        end
                    end
                    else
                    begin
                        if (store_empty)
                        begin
                            finish     = 1'b1;
                            fin_status = STAT_EMPTY;
                        end
                    end
                end
            end
            S_ENQ_CMP:
            begin
                mem_we = 1'b1;
                if (enq_keep)
                begin
                    finish     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    mem_wdata = rdata_reg;
                    p_next    = p_reg - ADDR_W'(1);
                    rd_addr   = p_reg - ADDR_W'(2);
                end
            end
            S_ENQ_LAST:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                finish     = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
            S_DEQ_HEAD:
            begin
                head_next = rdata_reg;
                deq_out   = 1'b1;
                if (count_reg == CNT_W'(1))
                begin
                    finish     = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    rd_addr = ADDR_W'(1);
                    p_next  = '0;
                end
            end
            S_DEQ_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_wdata = rdata_reg;
                deq_out   = 1'b1;
                if (deq_last)
                begin
                    finish     = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    rd_addr = p_reg + ADDR_W'(2);
                    p_next  = p_reg + ADDR_W'(1);
                end
            end
        endcase
    end

    // The entry fields are zero for anything but a successful dequeue.
    always_comb
    begin
        result_next.status       = fin_status;
        result_next.out_priority = deq_out ? head_next.prio : '0;
        result_next.out_payload  = deq_out ? head_next.payload : '0;
        result_next.entry_count  = count_next;
        result_next.is_empty     = (count_next == '0);
        result_next.is_full      = (count_next >= cap_eff);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            capacity_reg <= CNT_W'(16);
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= finish;
            if (capacity_we)
            begin
                capacity_reg <= capacity_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        op_reg   <= op_next;
        head_reg <= head_next;
        if (finish)
        begin
            result_reg <= result_next;
        end
    end

    // An accepted beat either keeps the block busy or finishes at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted beat neither started work nor produced a result");

    // A result is only delivered once the sequencer has returned to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // The reported count matches the held count.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.entry_count == count_reg))
        else $error("reported count differs from held count");

    // The held count never exceeds the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("held count above store depth");

endmodule
